/* hw/rtl/pcfich_pkg.sv */
// Shared constants, types and Gold sequence helpers for the PCFICH CFI decoder.
`timescale 1ns / 1ps

package pcfich_pkg;

    localparam int SOFT_WIDTH   = 8;
    localparam int CODEWORD_LEN = 32;
    localparam int POS_W        = $clog2(CODEWORD_LEN);
    localparam int SLOT_W       = 5;
    localparam int CELL_W       = 9;
    localparam int CFI_W        = 3;
    localparam int NUM_CFI      = 4;
    localparam int PICK_W       = $clog2(NUM_CFI);

    // Descrambled value and running correlation widths
    localparam int SD_W   = SOFT_WIDTH + 1;
    localparam int CORR_W = SOFT_WIDTH + POS_W + 1;

    // Gold sequence
    localparam int GOLD_LEN   = 31;
    localparam int GOLD_NC    = 1600;
    localparam int SEED_SHIFT = 9;
    localparam int SUB_W      = SLOT_W;
    localparam int ODD_W      = CELL_W + 1;
    localparam int PROD_W     = SUB_W + ODD_W;

    typedef logic signed [SOFT_WIDTH-1:0] soft_t;
    typedef logic signed [SD_W-1:0]       sd_t;
    typedef logic signed [CORR_W-1:0]     corr_t;
    typedef logic [GOLD_LEN-1:0]          gold_t;
    typedef logic [GOLD_LEN-1:0][GOLD_LEN-1:0] gold_mat_t;
    typedef logic [NUM_CFI-1:0][CODEWORD_LEN-1:0] cw_set_t;

    // Control from the decoder to the sequence generator
    typedef struct packed {
        logic step;
        logic load;
    } gold_ctrl_t;

    // Bit j set where chip j of the CFI codeword is +1
    localparam cw_set_t CW_PLUS = {
        32'hFFFF_FFFF,
        32'h2492_4924,
        32'h9249_2492,
        32'h4924_9249
    };

    function automatic gold_t adv_x1(input gold_t x);
        logic nb;
        nb = x[3] ^ x[0];
        return {nb, x[GOLD_LEN-1:1]};
    endfunction

    function automatic gold_t adv_x2(input gold_t x);
        logic nb;
        nb = x[3] ^ x[2] ^ x[1] ^ x[0];
        return {nb, x[GOLD_LEN-1:1]};
    endfunction

    // x1 after the Nc advance, starting from 1
    function automatic gold_t x1_start();
        gold_t v;
        v = gold_t'(1);
        for (int k = 0; k < GOLD_NC; k++)
        begin
            v = adv_x1(v);
        end
        return v;
    endfunction

    // Columns of the linear map seed -> x2 after the Nc advance
    function automatic gold_mat_t x2_adv_matrix();
        gold_mat_t m;
        gold_t     v;
        m = '0;
        for (int j = 0; j < GOLD_LEN; j++)
        begin
            v    = '0;
            v[j] = 1'b1;
            for (int k = 0; k < GOLD_NC; k++)
            begin
                v = adv_x2(v);
            end
            m[j] = v;
        end
        return m;
    endfunction

    localparam gold_t     X1_INIT    = x1_start();
    localparam gold_mat_t X2_ADV_MAT = x2_adv_matrix();

endpackage

/* hw/rtl/pcfich_if.sv */
// Valid/ready channel interfaces for the PCFICH CFI decoder.
`timescale 1ns / 1ps

interface pcfich_in_if;
    logic                  valid;
    logic                  ready;
    pcfich_pkg::soft_t     soft_value;
    logic [pcfich_pkg::SLOT_W-1:0] slot;

    modport source (output valid, output soft_value, output slot, input ready);
    modport sink   (input valid, input soft_value, input slot, output ready);
endinterface

interface pcfich_out_if;
    logic                         valid;
    logic                         ready;
    logic [pcfich_pkg::CFI_W-1:0] cfi;

    modport source (output valid, output cfi, input ready);
    modport sink   (input valid, input cfi, output ready);
endinterface

interface pcfich_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pcfich_pkg::CELL_W-1:0] cell_id;

    modport source (output valid, output cell_id, input ready);
    modport sink   (input valid, input cell_id, output ready);
endinterface

/* hw/rtl/pcfich_gold.sv */
// Gold scrambling sequence generator with per-codeword seeding and Nc advance.
`timescale 1ns / 1ps

module pcfich_gold
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pcfich_pkg::gold_ctrl_t        ctrl,
    input  logic [pcfich_pkg::SLOT_W-1:0] slot,
    input  logic [pcfich_pkg::CELL_W-1:0] cell_id,
    output logic                          chip
);

    pcfich_pkg::gold_t x1_reg;
    pcfich_pkg::gold_t x2_reg;
    pcfich_pkg::gold_t x1_next;
    pcfich_pkg::gold_t x2_next;
    pcfich_pkg::gold_t x1_cur;
    pcfich_pkg::gold_t x2_cur;
    pcfich_pkg::gold_t seed;
    pcfich_pkg::gold_t x2_init;
    logic [pcfich_pkg::SUB_W-1:0]  sub_p1;
    logic [pcfich_pkg::ODD_W-1:0]  cell_odd;
    logic [pcfich_pkg::PROD_W-1:0] prod;

    // Build c_init = (subframe+1)*(2*cell_id+1)*512 + cell_id
    assign sub_p1   = pcfich_pkg::SUB_W'(slot[pcfich_pkg::SLOT_W-1:1])
                    + pcfich_pkg::SUB_W'(1);
    assign cell_odd = {cell_id, 1'b1};
    assign prod     = pcfich_pkg::PROD_W'(sub_p1) * pcfich_pkg::PROD_W'(cell_odd);
    assign seed     = (pcfich_pkg::GOLD_LEN'(prod) << pcfich_pkg::SEED_SHIFT)
                    | pcfich_pkg::GOLD_LEN'(cell_id);

    // Apply the precomputed Nc advance as a GF(2) matrix
    always_comb
    begin
        x2_init = '0;
        for (int j = 0; j < pcfich_pkg::GOLD_LEN; j++)
        begin
            if (seed[j])
            begin
                x2_init = x2_init ^ pcfich_pkg::X2_ADV_MAT[j];
            end
        end
    end

    // Select seeded or running state, take the chip, advance by one
    always_comb
    begin
        x1_cur  = ctrl.load ? pcfich_pkg::X1_INIT : x1_reg;
        x2_cur  = ctrl.load ? x2_init : x2_reg;
        chip    = x1_cur[0] ^ x2_cur[0];
        x1_next = pcfich_pkg::adv_x1(x1_cur);
        x2_next = pcfich_pkg::adv_x2(x2_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
        end
        else if (ctrl.step)
        begin
            x1_reg <= x1_next;
            x2_reg <= x2_next;
        end
    end

endmodule

/* hw/rtl/pcfich_descramble_cfi_decode_top.sv */
// Top level of the PCFICH descrambler and CFI soft decoder.
`timescale 1ns / 1ps
//
// Usage:
//   din  : one soft decision word per handshake (soft_value, slot). Words
//          come in groups of 32, one PCFICH codeword; slot is used only at
//          the first word of each group to seed the scrambling sequence.
//   dout : one word (cfi, 1..4) after every 32nd input word.
//   cfg  : writes cell_id; always ready. Write it only while idle.
// Throughput: one input word per cycle while no result is blocked; the
//   descramble/accumulate step between the input register and the state
//   is combinational.
// Result path: the 32nd input word is loaded into the input register, then
//   the cfi word into the result register, unless a pending result stalls it.
// Reset: clears the input and result valids, the codeword position, the
//   correlations, the sequence state and cell_id (to 0).
// Stall: while a cfi word waits unaccepted, the stage holds its word only
//   if it would produce a new result; din keeps flowing otherwise, and one
//   word can wait in the input register.
//
module pcfich_descramble_cfi_decode_top
(
    input  logic         clk,
    input  logic         rst_n,
    pcfich_cfg_if.sink   cfg,
    pcfich_in_if.sink    din,
    pcfich_out_if.source dout
);

    logic [pcfich_pkg::CELL_W-1:0]      cell_id_reg;
    logic                               in_valid_reg;
    pcfich_pkg::soft_t                  soft_reg;
    logic [pcfich_pkg::SLOT_W-1:0]      slot_reg;
    logic [pcfich_pkg::POS_W-1:0]       pos_reg;
    pcfich_pkg::corr_t                  corr_reg [pcfich_pkg::NUM_CFI];
    pcfich_pkg::corr_t                  corr_next [pcfich_pkg::NUM_CFI];
    logic                               out_valid_reg;
    logic [pcfich_pkg::CFI_W-1:0]       cfi_reg;
    logic [pcfich_pkg::CFI_W-1:0]       cfi_next;
    logic                               fire;
    logic                               last;
    logic                               chip;
    pcfich_pkg::gold_ctrl_t             gold_ctrl;
    pcfich_pkg::sd_t                    s_ext;
    pcfich_pkg::sd_t                    sd;
    pcfich_pkg::corr_t                  best;
    logic [pcfich_pkg::PICK_W-1:0]      pick;

    // Configuration: always accept
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_id_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            cell_id_reg <= cfg.cell_id;
        end
    end

    // Handshake: stage advances unless a result would be blocked
    assign last     = (pos_reg == pcfich_pkg::POS_W'(pcfich_pkg::CODEWORD_LEN - 1));
    assign fire     = in_valid_reg && (!last || !out_valid_reg || dout.ready);
    assign din.ready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (din.ready)
        begin
            in_valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            soft_reg <= din.soft_value;
            slot_reg <= din.slot;
        end
    end

    // Scrambling sequence
    assign gold_ctrl.step = fire;
    assign gold_ctrl.load = (pos_reg == '0);

    pcfich_gold u_gold
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (gold_ctrl),
        .slot    (slot_reg),
        .cell_id (cell_id_reg),
        .chip    (chip)
    );

    // Descramble and accumulate against the four codewords
    always_comb
    begin
        s_ext = pcfich_pkg::sd_t'(soft_reg);
        sd    = chip ? -s_ext : s_ext;
        for (int i = 0; i < pcfich_pkg::NUM_CFI; i++)
        begin
            if (pcfich_pkg::CW_PLUS[i][pos_reg])
            begin
                corr_next[i] = corr_reg[i] + pcfich_pkg::corr_t'(sd);
            end
            else
            begin
                corr_next[i] = corr_reg[i] - pcfich_pkg::corr_t'(sd);
            end
        end
    end

    // Pick the first strictly largest correlation above zero
    always_comb
    begin
        best = '0;
        pick = '0;
        for (int i = 0; i < pcfich_pkg::NUM_CFI; i++)
        begin
            if (corr_next[i] > best)
            begin
                best = corr_next[i];
                pick = pcfich_pkg::PICK_W'(i);
            end
        end
        cfi_next = pcfich_pkg::CFI_W'(pick) + pcfich_pkg::CFI_W'(1);
    end

    // Codeword state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int i = 0; i < pcfich_pkg::NUM_CFI; i++)
            begin
                corr_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            pos_reg <= pos_reg + pcfich_pkg::POS_W'(1);
            for (int i = 0; i < pcfich_pkg::NUM_CFI; i++)
            begin
                corr_reg[i] <= last ? '0 : corr_next[i];
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && last)
        begin
            cfi_reg <= cfi_next;
        end
    end

    assign dout.valid = out_valid_reg;
    assign dout.cfi   = cfi_reg;

    // Checks
    a_wrap_emits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> out_valid_reg && (pos_reg == '0))
        else $error("codeword end did not raise a result");

    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == '0) |-> (corr_reg[0] == '0) && (corr_reg[1] == '0)
                            && (corr_reg[2] == '0) && (corr_reg[3] == '0))
        else $error("correlations not cleared at codeword start");

    a_hold_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(pos_reg))
        else $error("position moved without a word");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !dout.ready |-> !(fire && last))
        else $error("pending result overwritten");

    a_cfi_range: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> (cfi_reg != '0) && (cfi_reg <= pcfich_pkg::CFI_W'(pcfich_pkg::NUM_CFI)))
        else $error("cfi out of range");

endmodule

/* dv/testbench.sv */
// Testbench for the PCFICH descrambler and CFI soft decoder: stimulus, prediction and checks.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_SHOWN     = 10;
    localparam int LONG_HOLD     = 300;
    localparam int TOTAL_WORDS   = 1100;
    localparam int SETTLE_CYCLES = 4;
    localparam int SEED_SCALE    = 1 << 9;
    localparam int MAX_GAP       = 11;

    // Bit j set where chip j of the CFI codeword is +1; entry 0 is CFI 1
    localparam logic [pcfich_pkg::NUM_CFI-1:0][pcfich_pkg::CODEWORD_LEN-1:0] CFI_CHIPS = {
        32'hFFFF_FFFF,
        32'h2492_4924,
        32'h9249_2492,
        32'h4924_9249
    };

    // Tracks the decoder state and the queue of CFI words still owed
    class cfi_scoreboard;
        logic [pcfich_pkg::CELL_W-1:0]       cell_id;
        int                                  corr [pcfich_pkg::NUM_CFI];
        logic [pcfich_pkg::POS_W-1:0]        pos;
        logic [pcfich_pkg::CODEWORD_LEN-1:0] chips;
        logic [pcfich_pkg::CFI_W-1:0]        expected_cfi [$];
        int                                  fail_count;

        function new();
            cell_id    = '0;
            pos        = '0;
            chips      = '0;
            fail_count = 0;
            foreach (corr[i])
            begin
                corr[i] = 0;
            end
        endfunction

        // Gold sequence chips of one codeword for a cell and slot
        static function logic [pcfich_pkg::CODEWORD_LEN-1:0] gold_chips(
            logic [pcfich_pkg::CELL_W-1:0] cell_no,
            logic [pcfich_pkg::SLOT_W-1:0] slot_no);
            logic [30:0]                         x1;
            logic [30:0]                         x2;
            int unsigned                         sub;
            int unsigned                         c_init;
            logic [pcfich_pkg::CODEWORD_LEN-1:0] seq;
            sub    = int'(slot_no) >> 1;
            c_init = (sub + 1) * (2 * int'(cell_no) + 1) * SEED_SCALE + int'(cell_no);
            x1     = 31'd1;
            x2     = c_init[30:0];
            seq    = '0;
            for (int k = 0; k < pcfich_pkg::GOLD_NC + pcfich_pkg::CODEWORD_LEN; k++)
            begin
                if (k >= pcfich_pkg::GOLD_NC)
                begin
                    seq[k - pcfich_pkg::GOLD_NC] = x1[0] ^ x2[0];
                end
                x1 = {x1[3] ^ x1[0], x1[30:1]};
                x2 = {x2[3] ^ x2[2] ^ x2[1] ^ x2[0], x2[30:1]};
            end
            return seq;
        endfunction

        function void report_failure(string msg);
            if (fail_count < MAX_SHOWN)
            begin
                $display("%0t: %s", $time, msg);
            end
            fail_count++;
        endfunction

        // Descramble one accepted soft word and accumulate; owe a CFI at the 32nd
        function void note_soft_word(pcfich_pkg::soft_t value,
                                     logic [pcfich_pkg::SLOT_W-1:0] slot_no);
            int d;
            int best;
            int pick;
            if (pos == '0)
            begin
                chips = gold_chips(cell_id, slot_no);
            end
            d = chips[pos] ? -int'(value) : int'(value);
            for (int i = 0; i < pcfich_pkg::NUM_CFI; i++)
            begin
                corr[i] += CFI_CHIPS[i][pos] ? d : -d;
            end
            if (pos == pcfich_pkg::POS_W'(pcfich_pkg::CODEWORD_LEN - 1))
            begin
                // First strictly largest above zero wins, else CFI 1
                best = 0;
                pick = 0;
                for (int i = 0; i < pcfich_pkg::NUM_CFI; i++)
                begin
                    if (corr[i] > best)
                    begin
                        best = corr[i];
                        pick = i;
                    end
                    corr[i] = 0;
                end
                expected_cfi.push_back(pcfich_pkg::CFI_W'(pick + 1));
            end
            // Position wraps from 31 back to 0
            pos = pos + 1'b1;
        endfunction

        function void check_cfi(logic [pcfich_pkg::CFI_W-1:0] got);
            logic [pcfich_pkg::CFI_W-1:0] want;
            if (expected_cfi.size() == 0)
            begin
                report_failure($sformatf("cfi word %0d arrived with nothing expected", got));
            end
            else
            begin
                want = expected_cfi.pop_front();
                if (got !== want)
                begin
                    report_failure($sformatf("cfi mismatch: expected %0d, got %0d", want, got));
                end
            end
        endfunction

        function int pending();
            return expected_cfi.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pcfich_cfg_if cfg_ch ();
    pcfich_in_if  din_ch ();
    pcfich_out_if dout_ch ();

    pcfich_descramble_cfi_decode_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .din   (din_ch),
        .dout  (dout_ch)
    );

    cfi_scoreboard                 sb = new();
    int                            plan [pcfich_pkg::CODEWORD_LEN];
    logic [pcfich_pkg::CELL_W-1:0] cur_cell = '0;
    int                            words_sent = 0;
    int                            cycle_count = 0;
    int                            rx_gap = 0;
    bit                            no_gaps = 0;
    bit                            rx_hold = 0;
    bit                            hold_start = 0;

    // Clock generation
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Observe handshakes on all three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (din_ch.valid && din_ch.ready)
            begin
                sb.note_soft_word(din_ch.soft_value, din_ch.slot);
            end
            if (dout_ch.valid && dout_ch.ready)
            begin
                sb.check_cfi(dout_ch.cfi);
                rx_gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                sb.cell_id = cfg_ch.cell_id;
            end
        end
    end

    // Drive the result ready: random gaps after each word, plus the long hold
    initial
    begin
        dout_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold || rx_gap > 0)
            begin
                dout_ch.ready <= 1'b0;
                if (!rx_hold)
                begin
                    rx_gap--;
                end
            end
            else
            begin
                dout_ch.ready <= 1'b1;
            end
        end
    end

    // Hold the result side off for a long stretch once requested
    initial
    begin
        wait (hold_start);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold = 1'b0;
    end

    task automatic send_word(pcfich_pkg::soft_t value, logic [pcfich_pkg::SLOT_W-1:0] slot_no);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap)
        begin
            @(negedge clk);
            din_ch.valid <= 1'b0;
        end
        @(negedge clk);
        din_ch.valid      <= 1'b1;
        din_ch.soft_value <= value;
        din_ch.slot       <= slot_no;
        do @(posedge clk); while (!din_ch.ready);
        words_sent++;
    endtask

    // Send the 32 planned values (clipped), scrambled when scramble_it so they descramble to the plan
    task automatic send_codeword(logic [pcfich_pkg::SLOT_W-1:0] slot_no, bit scramble_it);
        logic [pcfich_pkg::CODEWORD_LEN-1:0] seq;
        int                                  v;
        seq = scramble_it ? cfi_scoreboard::gold_chips(cur_cell, slot_no) : '0;
        for (int j = 0; j < pcfich_pkg::CODEWORD_LEN; j++)
        begin
            v = seq[j] ? -plan[j] : plan[j];
            if (v > 127)
            begin
                v = 127;
            end
            if (v < -128)
            begin
                v = -128;
            end
            send_word(pcfich_pkg::soft_t'(v),
                      (j == 0) ? slot_no : pcfich_pkg::SLOT_W'($urandom_range(0, 31)));
        end
    endtask

    function automatic void plan_fill(int v);
        foreach (plan[j])
        begin
            plan[j] = v;
        end
    endfunction

    function automatic void plan_cfi(int idx, int amp, int noise);
        foreach (plan[j])
        begin
            plan[j] = (CFI_CHIPS[idx][j] ? amp : -amp)
                      + int'($urandom_range(0, 2 * noise)) - noise;
        end
    endfunction

    // Drop valid and wait until every owed CFI word has come out
    task automatic settle();
        @(negedge clk);
        din_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cell(logic [pcfich_pkg::CELL_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.cell_id <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cur_cell = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_codeword();
        logic [pcfich_pkg::SLOT_W-1:0] slot_no;
        int                            kind;
        int                            amp;
        slot_no = ($urandom_range(0, 7) == 0) ? pcfich_pkg::SLOT_W'($urandom_range(20, 31))
                                              : pcfich_pkg::SLOT_W'($urandom_range(0, 19));
        kind = $urandom_range(0, 9);
        if (kind <= 6)
        begin
            // Clean or noisy CFI codeword
            amp = $urandom_range(1, 127);
            plan_cfi($urandom_range(0, pcfich_pkg::NUM_CFI - 1), amp, $urandom_range(0, 127));
            send_codeword(slot_no, 1'b1);
        end
        else
        begin
            foreach (plan[j])
            begin
                case (kind)
                    7: plan[j] = int'($urandom_range(0, 255)) - 128;
                    8: plan[j] = int'($urandom_range(0, 4)) - 2;
                    default: plan[j] = $urandom_range(0, 1) ? -128 : 127;
                endcase
            end
            send_codeword(slot_no, 1'b0);
        end
    endtask

    initial
    begin
        int                            phase;
        logic [pcfich_pkg::CELL_W-1:0] cell_sel;
        rst_n             = 1'b0;
        din_ch.valid      = 1'b0;
        din_ch.soft_value = '0;
        din_ch.slot       = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.cell_id    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Cell 0 from reset: all-zero codeword gives CFI 1
        plan_fill(0);
        send_codeword(5'd0, 1'b0);
        // Tie between CFI 1 and CFI 4, then between CFI 2 and CFI 4
        plan_fill(0);
        plan[0] = 60;
        send_codeword(5'd5, 1'b1);
        plan_fill(0);
        plan[1] = 60;
        send_codeword(5'd6, 1'b1);

        // Cell id above 503, top slot, most negative soft values
        write_cell(9'd511);
        plan_fill(-128);
        send_codeword(5'd31, 1'b0);
        plan_cfi(3, 127, 0);
        send_codeword(5'd30, 1'b1);

        // Highest legal cell id, most positive soft values
        write_cell(9'd503);
        plan_fill(127);
        send_codeword(5'd19, 1'b0);
        plan_cfi(1, 100, 0);
        send_codeword(5'd20, 1'b1);
        plan_cfi(2, 90, 10);
        send_codeword(5'd0, 1'b1);

        // Random phases, each under its own cell id
        phase = 0;
        while (words_sent + 2 * pcfich_pkg::CODEWORD_LEN < TOTAL_WORDS)
        begin
            case (phase)
                0: cell_sel = 9'd0;
                1: cell_sel = 9'd1;
                3: cell_sel = 9'd511;
                default: cell_sel = pcfich_pkg::CELL_W'($urandom_range(0, 511));
            endcase
            write_cell(cell_sel);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (phase == 2)
            begin
                // Back-to-back input while the result side is held off
                no_gaps    = 1'b1;
                hold_start = 1'b1;
            end
            repeat ($urandom_range(2, 5)) random_codeword();
            phase++;
        end

        settle();
        if (sb.fail_count == 0 && sb.pending() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
